// File: rtl/updec_pkg.sv
// ----------------------------------------------------------------------------
// updec_pkg: URL percent decoder shared types
// Transaction structs, pending-mode encoding and hex digit helpers.
// ----------------------------------------------------------------------------
package updec_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // One input transaction: a URL character and the end-of-string flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    // Pending mode: nothing held, a percent sign held, percent plus one digit held
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_PCT   = 3'b010,
        MODE_DIGIT = 3'b100
    } t_mode;

    // Decoder results for one input transaction
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
        t_mode      n_mode;
        logic       held_we;
    } t_dec;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_val = 4'd0;
        end
    endfunction

endpackage

// File: rtl/url_percent_decoder_unit.sv
// Results are registered in a three-entry result queue whose head drives o_out.
// Throughput: one input transaction per cycle while each yields at most one result
// and the output is not stalled; a transaction with two results is held back by the
// single output port draining the result queue (input stalls at two queued).
// Reset (synchronous, active low) empties the queue and clears the pending mode.
// ----------------------------------------------------------------------------
// url_percent_decoder_unit: streaming URL percent decoder
// Decodes %XX escapes on a byte stream, one character per transaction.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  updec_pkg::t_in_item  i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output updec_pkg::t_out_item o_out
);

    localparam int QDEPTH = 3;

    updec_pkg::t_mode     r_mode;
    logic [7:0]           r_held;
    updec_pkg::t_out_item r_slot [QDEPTH];
    updec_pkg::t_out_item n_slot [QDEPTH];
    updec_pkg::t_out_item sh     [QDEPTH];
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic [1:0]           base;
    logic                 accept;
    logic                 pop;
    updec_pkg::t_dec      dec;

    updec_core u_core (
        .i_in   (i_in),
        .i_mode (r_mode),
        .i_held (r_held),
        .o_dec  (dec)
    );

    // Handshakes: room for two results means the input may go
    assign o_stall = (r_cnt >= 2'd2);
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_out   = r_slot[0];

    // Advance the queue and append new results
    always_comb begin
        sh = r_slot;
        if (pop) begin
            sh[0] = r_slot[1];
            sh[1] = r_slot[2];
        end
        base   = r_cnt - {1'b0, pop};
        n_slot = sh;
        n_cnt  = base;
        if (accept) begin
            for (int i = 0; i < QDEPTH; i++) begin
                if (dec.cnt != 2'd0 && base == 2'(i)) begin
                    n_slot[i] = dec.res0;
                end
                if (dec.cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
                    n_slot[i] = dec.res1;
                end
            end
            n_cnt = base + dec.cnt;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_mode <= updec_pkg::MODE_IDLE;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_mode <= dec.n_mode;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (accept && dec.held_we) begin
            r_held <= i_in.in_byte;
        end
    end

endmodule

// File: rtl/updec_core.sv
// ----------------------------------------------------------------------------
// updec_core: per-character decode step
// Works out the zero, one or two results of one input transaction and the
// next pending mode, from the character, its end flag and the held state.
// ----------------------------------------------------------------------------
module updec_core (
    input  updec_pkg::t_in_item i_in,
    input  updec_pkg::t_mode    i_mode,
    input  logic [7:0]          i_held,
    output updec_pkg::t_dec     o_dec
);

    logic [7:0]       ca;
    logic [7:0]       cb;
    logic             ae;
    logic             be;
    logic             ae_eff;
    logic             be_eff;
    logic             b_hex;
    logic             b_pct;
    updec_pkg::t_mode n_mode;
    logic             held_we;

    assign b_hex = updec_pkg::hex_ok(i_in.in_byte);
    assign b_pct = (i_in.in_byte == updec_pkg::PCT_CHAR);

    // Pick candidate bytes and the next mode
    always_comb begin
        ca      = i_in.in_byte;
        cb      = i_in.in_byte;
        ae      = 1'b0;
        be      = 1'b0;
        n_mode  = updec_pkg::MODE_IDLE;
        held_we = 1'b0;
        unique case (i_mode)
            updec_pkg::MODE_PCT: begin
                if (i_in.in_last) begin
                    // percent among the last two bytes passes through
                    ca = updec_pkg::PCT_CHAR;
                    ae = 1'b1;
                    be = 1'b1;
                end else if (b_hex) begin
                    held_we = 1'b1;
                    n_mode  = updec_pkg::MODE_DIGIT;
                end else if (b_pct) begin
                    n_mode = updec_pkg::MODE_PCT;
                end else begin
                    ae = 1'b1;
                end
            end
            updec_pkg::MODE_DIGIT: begin
                if (b_hex) begin
                    ca = {updec_pkg::hex_val(i_held), updec_pkg::hex_val(i_in.in_byte)};
                    ae = 1'b1;
                end else begin
                    // drop the percent, keep the held digit
                    ca = i_held;
                    ae = 1'b1;
                    if (i_in.in_last) begin
                        be = 1'b1;
                    end else if (b_pct) begin
                        n_mode = updec_pkg::MODE_PCT;
                    end else begin
                        be = 1'b1;
                    end
                end
            end
            default: begin
                if (i_in.in_last) begin
                    ae = 1'b1;
                end else if (b_pct) begin
                    n_mode = updec_pkg::MODE_PCT;
                end else begin
                    ae = 1'b1;
                end
            end
        endcase
        if (i_in.in_last) begin
            n_mode = updec_pkg::MODE_IDLE;
        end
    end

    // Drop zero bytes and pack the survivors
    assign ae_eff = ae && (ca != 8'd0);
    assign be_eff = be && (cb != 8'd0);

    always_comb begin
        o_dec.n_mode  = n_mode;
        o_dec.held_we = held_we;
        o_dec.cnt = {1'b0, ae_eff} + {1'b0, be_eff};
        o_dec.res0.out_byte   = ae_eff ? ca : cb;
        o_dec.res0.has_byte   = 1'b1;
        o_dec.res0.run_last   = !(ae_eff && be_eff);
        o_dec.res0.string_end = i_in.in_last && !(ae_eff && be_eff);
        o_dec.res1.out_byte   = cb;
        o_dec.res1.has_byte   = 1'b1;
        o_dec.res1.run_last   = 1'b1;
        o_dec.res1.string_end = i_in.in_last;
        // end-only marker when the last character yields nothing
        if (i_in.in_last && !ae_eff && !be_eff) begin
            o_dec.cnt             = 2'd1;
            o_dec.res0.out_byte   = 8'd0;
            o_dec.res0.has_byte   = 1'b0;
            o_dec.res0.run_last   = 1'b1;
            o_dec.res0.string_end = 1'b1;
        end
    end

endmodule

// File: rtl/updec_checker.sv
// ----------------------------------------------------------------------------
// updec_checker: port-level checks for the URL percent decoder
// Watches the result channel for well-formed transactions.
// ----------------------------------------------------------------------------
module updec_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input updec_pkg::t_out_item o_out
);

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // End-only marker closes both the run and the string
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.has_byte |-> o_out.run_last && o_out.string_end)
        else $error("end-only marker without end flags");

    // String end is always the last result of its transaction
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.string_end |-> o_out.run_last)
        else $error("string end before last result of transaction");

    // Data bytes are never zero
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.has_byte |-> o_out.out_byte != 8'd0)
        else $error("zero data byte emitted");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind url_percent_decoder_unit updec_checker u_updec_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
